// ===== design/ttcp_pkg.sv =====
`default_nettype none
package ttcp_pkg;

  localparam int CoordW   = 16;
  localparam int CfgW     = 16;
  localparam int HalfW    = 13;
  localparam int IdxW     = 3;
  localparam int VW       = 21;
  localparam int OutW     = 20;
  localparam int Lanes    = 6;
  localparam int QuoW     = 30;
  localparam int RemW     = 52;
  localparam int ZW       = 21;
  localparam int DotW     = 68;

  localparam int RotHalf    = 8192;
  localparam int RotShift   = 14;
  localparam int ZOffset    = 12288;
  localparam int NoDivZ     = 4096;
  localparam int RoundBias  = 128;
  localparam int RoundShift = 8;
  localparam int OutMax     = 524287;
  localparam int OutMin     = -524288;

  typedef enum logic [IdxW-1:0] {
    CFG_COS_Z,
    CFG_SIN_Z,
    CFG_COS_X,
    CFG_SIN_X,
    CFG_X_FOCAL,
    CFG_Y_FOCAL,
    CFG_HALF_W,
    CFG_HALF_H
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic                   visible;
    logic signed [OutW-1:0] screen_a_x;
    logic signed [OutW-1:0] screen_a_y;
    logic signed [OutW-1:0] screen_b_x;
    logic signed [OutW-1:0] screen_b_y;
    logic signed [OutW-1:0] screen_c_x;
    logic signed [OutW-1:0] screen_c_y;
  } tri_out_t;

  typedef struct packed {
    logic signed [CfgW-1:0] cos_z;
    logic signed [CfgW-1:0] sin_z;
    logic signed [CfgW-1:0] cos_x;
    logic signed [CfgW-1:0] sin_x;
    logic [CfgW-1:0]        x_focal;
    logic [CfgW-1:0]        y_focal;
    logic [HalfW-1:0]       half_w;
    logic [HalfW-1:0]       half_h;
  } cfg_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vert_t;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [RemW-1:0] rem;
    logic [ZW-1:0]   div;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                   vis;
    lane_t [Lanes-1:0]      lane;
  } div_item_t;

endpackage
`default_nettype wire

// ===== design/ttcp_rotate.sv =====
`default_nettype none
module ttcp_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttcp_pkg::tri_in_t  in_data,
  input  ttcp_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output ttcp_pkg::vert_t [2:0] out_vert
);
  import ttcp_pkg::*;

  logic [3:0] vld;
  logic [3:0] en;

  assign en[3] = !vld[3] || out_ready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  logic signed [CoordW-1:0] ix [3];
  logic signed [CoordW-1:0] iy [3];
  logic signed [CoordW-1:0] iz [3];

  assign ix[0] = in_data.a_x;
  assign iy[0] = in_data.a_y;
  assign iz[0] = in_data.a_z;
  assign ix[1] = in_data.b_x;
  assign iy[1] = in_data.b_y;
  assign iz[1] = in_data.b_z;
  assign ix[2] = in_data.c_x;
  assign iy[2] = in_data.c_y;
  assign iz[2] = in_data.c_z;

  // stage 1: Z rotation products
  logic signed [31:0] p_xc [3];
  logic signed [31:0] p_ys [3];
  logic signed [31:0] p_xs [3];
  logic signed [31:0] p_yc [3];
  logic signed [CoordW-1:0] z1 [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        p_xc[k] <= ix[k] * cfg.cos_z;
        p_ys[k] <= iy[k] * cfg.sin_z;
        p_xs[k] <= ix[k] * cfg.sin_z;
        p_yc[k] <= iy[k] * cfg.cos_z;
        z1[k]   <= iz[k];
      end
    end
  end

  // stage 2: round Z rotation
  logic signed [32:0] sx [3];
  logic signed [32:0] sy [3];
  logic signed [18:0] zx2 [3];
  logic signed [18:0] zy2 [3];
  logic signed [CoordW-1:0] z2 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sx[k] = 33'(p_xc[k]) - 33'(p_ys[k]) + 33'(RotHalf);
      sy[k] = 33'(p_xs[k]) + 33'(p_yc[k]) + 33'(RotHalf);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        zx2[k] <= 19'(sx[k] >>> RotShift);
        zy2[k] <= 19'(sy[k] >>> RotShift);
        z2[k]  <= z1[k];
      end
    end
  end

  // stage 3: X rotation products
  logic signed [34:0] q_yc [3];
  logic signed [34:0] q_zs [3];
  logic signed [34:0] q_ys [3];
  logic signed [34:0] q_zc [3];
  logic signed [18:0] zx3 [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        q_yc[k] <= zy2[k] * cfg.cos_x;
        q_zs[k] <= z2[k] * cfg.sin_x;
        q_ys[k] <= zy2[k] * cfg.sin_x;
        q_zc[k] <= z2[k] * cfg.cos_x;
        zx3[k]  <= zx2[k];
      end
    end
  end

  // stage 4: round X rotation, move along z
  logic signed [35:0] ty [3];
  logic signed [35:0] tz [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ty[k] = 36'(q_yc[k]) - 36'(q_zs[k]) + 36'(RotHalf);
      tz[k] = 36'(q_ys[k]) + 36'(q_zc[k]) + 36'(RotHalf);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        out_vert[k].x <= VW'(zx3[k]);
        out_vert[k].y <= VW'(ty[k] >>> RotShift);
        out_vert[k].z <= VW'((tz[k] >>> RotShift) + 36'(ZOffset));
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ttcp_setup.sv =====
`default_nettype none
module ttcp_setup (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttcp_pkg::vert_t [2:0] in_vert,
  input  ttcp_pkg::cfg_t        cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ttcp_pkg::div_item_t   out_data
);
  import ttcp_pkg::*;

  logic [3:0] vld;
  logic [3:0] en;

  assign en[3] = !vld[3] || out_ready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  // sign of a.(b x c) equals sign of ((b-a) x (c-a)).a
  logic signed [16:0] fx;
  logic signed [16:0] fy;
  logic signed [13:0] hw;
  logic signed [13:0] hh;

  assign fx = $signed({1'b0, cfg.x_focal});
  assign fy = $signed({1'b0, cfg.y_focal});
  assign hw = $signed({1'b0, cfg.half_w});
  assign hh = $signed({1'b0, cfg.half_h});

  // stage 5
  logic signed [2*VW-1:0] pr [6];
  logic signed [VW+16:0]  pf [Lanes];
  vert_t                  a1;
  logic signed [VW-1:0]   zz1 [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pr[0] <= in_vert[1].y * in_vert[2].z;
      pr[1] <= in_vert[1].z * in_vert[2].y;
      pr[2] <= in_vert[1].z * in_vert[2].x;
      pr[3] <= in_vert[1].x * in_vert[2].z;
      pr[4] <= in_vert[1].x * in_vert[2].y;
      pr[5] <= in_vert[1].y * in_vert[2].x;
      a1    <= in_vert[0];
      for (int k = 0; k < 3; k++) begin
        pf[2*k]   <= in_vert[k].x * fx;
        pf[2*k+1] <= in_vert[k].y * fy;
        zz1[k]    <= in_vert[k].z;
      end
    end
  end

  // stage 6
  logic signed [2*VW:0]   cr [3];
  logic signed [RemW-1:0] m2 [Lanes];
  vert_t                  a2;
  logic signed [VW-1:0]   zz2 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        cr[k] <= (2*VW+1)'(pr[2*k]) - (2*VW+1)'(pr[2*k+1]);
        m2[2*k]   <= pf[2*k] * hw;
        m2[2*k+1] <= pf[2*k+1] * hh;
        zz2[k] <= zz1[k];
      end
      a2 <= a1;
    end
  end

  // stage 7
  logic signed [VW-1:0]   acomp [3];
  logic signed [VW+22:0]  pl [3];
  logic signed [2*VW-1:0] ph [3];
  logic signed [VW-1:0]   zz [3];
  logic                   neg3 [Lanes];
  logic [RemW-1:0]        mag3 [Lanes];
  logic [ZW-1:0]          den3 [Lanes];

  assign acomp[0] = a2.x;
  assign acomp[1] = a2.y;
  assign acomp[2] = a2.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      zz[k] = (zz2[k] == '0) ? VW'(NoDivZ) : zz2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        pl[k] <= $signed({1'b0, cr[k][21:0]}) * acomp[k];
        ph[k] <= $signed(cr[k][2*VW:22]) * acomp[k];
      end
      for (int l = 0; l < Lanes; l++) begin
        neg3[l] <= m2[l][RemW-1] ^ zz[l/2][VW-1];
        mag3[l] <= m2[l][RemW-1] ? RemW'(-m2[l]) : RemW'(m2[l]);
        den3[l] <= zz[l/2][VW-1] ? ZW'(-zz[l/2]) : ZW'(zz[l/2]);
      end
    end
  end

  // stage 8
  logic signed [DotW-1:0] dot;

  always_comb begin
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      dot = dot + (DotW'(ph[k]) <<< 22) + DotW'(pl[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_data.vis <= dot[DotW-1];
      for (int l = 0; l < Lanes; l++) begin
        out_data.lane[l].neg <= neg3[l];
        out_data.lane[l].ovf <= (mag3[l] >> QuoW) >= RemW'(den3[l]);
        out_data.lane[l].rem <= mag3[l];
        out_data.lane[l].div <= den3[l];
        out_data.lane[l].quo <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ttcp_divide.sv =====
`default_nettype none
module ttcp_divide (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttcp_pkg::div_item_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ttcp_pkg::div_item_t out_data
);
  import ttcp_pkg::*;

  logic [QuoW-1:0] vld;
  logic [QuoW-1:0] en;
  div_item_t       st [QuoW];

  assign in_ready  = en[0];
  assign out_valid = vld[QuoW-1];
  assign out_data  = st[QuoW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < QuoW; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QuoW; k++) begin : g_step
    localparam int B = QuoW - 1 - k;
    div_item_t       src;
    div_item_t       nxt;
    logic [RemW-1:0] sh [Lanes];

    if (k == 0) begin : g_first
      assign src = in_data;
    end else begin : g_rest
      assign src = st[k-1];
    end

    if (k == QuoW - 1) begin : g_last
      assign en[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !vld[k] || en[k+1];
    end

    always_comb begin
      nxt = src;
      for (int l = 0; l < Lanes; l++) begin
        sh[l] = RemW'(src.lane[l].div) << B;
        if (src.lane[l].rem >= sh[l]) begin
          nxt.lane[l].rem    = src.lane[l].rem - sh[l];
          nxt.lane[l].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) st[k] <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ttcp_finish.sv =====
`default_nettype none
module ttcp_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttcp_pkg::div_item_t in_data,
  input  ttcp_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output ttcp_pkg::tri_out_t  out_data
);
  import ttcp_pkg::*;

  logic [1:0] vld;
  logic [1:0] en;

  assign en[1] = !vld[1] || out_ready;
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  // stage 1: signed floor quotient, round by 256
  logic signed [31:0] qs [Lanes];
  logic signed [23:0] t1 [Lanes];
  logic               ovf1 [Lanes];
  logic               neg1 [Lanes];
  logic               vis1;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      qs[l] = $signed({2'b00, in_data.lane[l].quo});
      if (in_data.lane[l].neg) begin
        qs[l] = -(qs[l] + ((in_data.lane[l].rem != '0) ? 32'sd1 : 32'sd0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < Lanes; l++) begin
        t1[l]   <= 24'((qs[l] + 32'(RoundBias)) >>> RoundShift);
        ovf1[l] <= in_data.lane[l].ovf;
        neg1[l] <= in_data.lane[l].neg;
      end
      vis1 <= in_data.vis;
    end
  end

  // stage 2: screen offset and saturation
  logic signed [24:0]     s [Lanes];
  logic signed [OutW-1:0] sat [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (l % 2 == 0) begin
        s[l] = 25'(t1[l]) + $signed({8'b0, cfg.half_w, 4'b0});
      end else begin
        s[l] = 25'(t1[l]) + $signed({8'b0, cfg.half_h, 4'b0});
      end
      if (!vis1) begin
        sat[l] = '0;
      end else if (ovf1[l]) begin
        sat[l] = neg1[l] ? OutW'(OutMin) : OutW'(OutMax);
      end else if (s[l] > 25'(OutMax)) begin
        sat[l] = OutW'(OutMax);
      end else if (s[l] < 25'(OutMin)) begin
        sat[l] = OutW'(OutMin);
      end else begin
        sat[l] = OutW'(s[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_data.visible    <= vis1;
      out_data.screen_a_x <= sat[0];
      out_data.screen_a_y <= sat[1];
      out_data.screen_b_x <= sat[2];
      out_data.screen_b_y <= sat[3];
      out_data.screen_c_x <= sat[4];
      out_data.screen_c_y <= sat[5];
    end
  end

endmodule
`default_nettype wire

// ===== design/triangle_transform_cull_project_unit.sv =====
`default_nettype none
// Triangle transform, back-face cull and perspective projection.
// Input channel (in_valid/in_ready/in_data): one triangle per transfer,
// nine signed Q4.12 coordinates. Output channel (out_valid/out_ready/
// out_data): one result per triangle, in order: visible flag and six
// saturated screen coordinates in sixteenth pixels, all zero when culled.
// Config port: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
// write only while no triangle is in flight.
// The pipeline has 4 rotation stages, 4 cull/setup stages, 30 divider
// stages (one quotient bit per stage per lane, six lanes), 2 finish stages.
// Throughput is one triangle per cycle while the receiver does not stall.
// Every stage holds its own valid bit and loads whenever it or the stage
// after it can move, so bubbles close up while the receiver stalls and
// input keeps being taken until all 40 stages are full.
// Synchronous reset empties the pipeline and loads the default rotation
// (identity), unit focal scales and a 256 pixel half screen.
module triangle_transform_cull_project_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ttcp_pkg::tri_in_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ttcp_pkg::tri_out_t            out_data,
  input  logic                          cfg_wr_en,
  input  logic [ttcp_pkg::IdxW-1:0]     cfg_index,
  input  logic [ttcp_pkg::CfgW-1:0]     cfg_data
);
  import ttcp_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_z   <= 16'sd16384;
      cfg.sin_z   <= '0;
      cfg.cos_x   <= 16'sd16384;
      cfg.sin_x   <= '0;
      cfg.x_focal <= 16'd4096;
      cfg.y_focal <= 16'd4096;
      cfg.half_w  <= 13'd256;
      cfg.half_h  <= 13'd256;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COS_Z:   cfg.cos_z   <= $signed(cfg_data);
        CFG_SIN_Z:   cfg.sin_z   <= $signed(cfg_data);
        CFG_COS_X:   cfg.cos_x   <= $signed(cfg_data);
        CFG_SIN_X:   cfg.sin_x   <= $signed(cfg_data);
        CFG_X_FOCAL: cfg.x_focal <= cfg_data;
        CFG_Y_FOCAL: cfg.y_focal <= cfg_data;
        CFG_HALF_W:  cfg.half_w  <= cfg_data[HalfW-1:0];
        CFG_HALF_H:  cfg.half_h  <= cfg_data[HalfW-1:0];
        default: ;
      endcase
    end
  end

  logic        rot_valid;
  logic        rot_ready;
  vert_t [2:0] rot_vert;
  logic        set_valid;
  logic        set_ready;
  div_item_t   set_data;
  logic        div_valid;
  logic        div_ready;
  div_item_t   div_data;

  ttcp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_vert  (rot_vert)
  );

  ttcp_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_vert   (rot_vert),
    .cfg       (cfg),
    .out_valid (set_valid),
    .out_ready (set_ready),
    .out_data  (set_data)
  );

  ttcp_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (set_valid),
    .in_ready  (set_ready),
    .in_data   (set_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  ttcp_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_culled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.visible |->
      (out_data.screen_a_x == '0 && out_data.screen_a_y == '0 &&
       out_data.screen_b_x == '0 && out_data.screen_b_y == '0 &&
       out_data.screen_c_x == '0 && out_data.screen_c_y == '0))
    else $error("culled triangle with nonzero screen coordinates");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule
`default_nettype wire
